[design/heat_phase_stencil_step_1d_defines.svh]
// Assertion macros shared by the stencil step RTL.
// Every user has i_clk and i_rst_n in scope; no other dependencies.
`ifndef HEAT_PHASE_STENCIL_STEP_1D_DEFINES_SVH
`define HEAT_PHASE_STENCIL_STEP_1D_DEFINES_SVH

// Same-cycle implication, checked out of reset.
`define HPSS_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked out of reset.
`define HPSS_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[design/hpss_pkg.sv]
// Package for the 1-D heat/phase stencil step: widths, job and control structs,
// register indexes and saturation helpers. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package hpss_pkg;

    localparam int FRAC_BITS = 24;
    localparam int DATA_W    = 32;
    localparam int COEF_W    = 31;

    // multiplier operands: A holds the 34-bit laplacian, 1-phi or a coefficient, B a 32-bit value
    localparam int A_W    = DATA_W + 2;
    localparam int B_W    = DATA_W;
    localparam int HALF_W = A_W / 2;
    localparam int LO_W   = HALF_W + B_W;
    localparam int HI_W   = (A_W - HALF_W) + B_W;
    localparam int PROD_W = A_W + B_W;
    localparam int MAGQ_W = PROD_W - FRAC_BITS;
    localparam int RES_W  = MAGQ_W + 1;
    localparam int WIDE_W = RES_W + 2;

    localparam int QDEPTH = 2;
    localparam int QPTR_W = $clog2(QDEPTH);
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_DIFFUSION = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TIME_STEP = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_LATENT    = 2'd2;

    localparam logic [COEF_W-1:0] DIFFUSION_RST = COEF_W'(167772);
    localparam logic [COEF_W-1:0] TIME_STEP_RST = COEF_W'(167772);
    localparam logic [COEF_W-1:0] LATENT_RST    = COEF_W'(83886080);

    localparam logic signed [A_W-1:0] ONE_Q = A_W'(1) << FRAC_BITS;

    localparam logic signed [DATA_W-1:0] SAT_MAX = {1'b0, {(DATA_W-1){1'b1}}};
    localparam logic signed [DATA_W-1:0] SAT_MIN = {1'b1, {(DATA_W-1){1'b0}}};

    typedef struct packed {
        logic                     has_mid;
        logic                     interior;
        logic                     last;
        logic signed [DATA_W-1:0] mid_temp;
        logic signed [DATA_W-1:0] mid_phase;
        logic signed [A_W-1:0]    lap;
        logic signed [DATA_W-1:0] temp;
        logic signed [DATA_W-1:0] phase;
    } t_job;

    typedef struct packed {
        logic [COEF_W-1:0] diffusion_coef;
        logic [COEF_W-1:0] time_step;
        logic [COEF_W-1:0] latent_gain;
    } t_coefs;

    typedef struct packed {
        logic                  start;
        logic signed [A_W-1:0] a;
        logic signed [B_W-1:0] b;
    } t_mul_req;

    typedef struct packed {
        logic                    done;
        logic signed [RES_W-1:0] res;
    } t_mul_rsp;

    function automatic logic signed [WIDE_W-1:0] sext_w(input logic signed [DATA_W-1:0] x);
        sext_w = {{(WIDE_W-DATA_W){x[DATA_W-1]}}, x};
    endfunction

    function automatic logic signed [DATA_W-1:0] sat32(input logic signed [WIDE_W-1:0] v);
        logic [WIDE_W-DATA_W:0] hi;
        hi = v[WIDE_W-1:DATA_W-1];
        if (!v[WIDE_W-1] && (|hi)) begin
            sat32 = SAT_MAX;
        end else if (v[WIDE_W-1] && !(&hi)) begin
            sat32 = SAT_MIN;
        end else begin
            sat32 = v[DATA_W-1:0];
        end
    endfunction

endpackage

`default_nettype wire

[design/hpss_if.sv]
// Channel interfaces of the stencil step: cell input, result output, config write.
// Depends on hpss_pkg.
`timescale 1ns / 1ps
`default_nettype none

interface hpss_cell_if import hpss_pkg::*; ();
    logic                     valid;
    logic                     ready;
    logic signed [DATA_W-1:0] cell_temp_in;
    logic signed [DATA_W-1:0] cell_phase_in;
    logic                     last_in_sweep;

    modport source (output valid, cell_temp_in, cell_phase_in, last_in_sweep, input ready);
    modport sink   (input valid, cell_temp_in, cell_phase_in, last_in_sweep, output ready);
endinterface

interface hpss_res_if import hpss_pkg::*; ();
    logic                     valid;
    logic                     ready;
    logic signed [DATA_W-1:0] cell_temp_out;
    logic signed [DATA_W-1:0] cell_phase_out;
    logic                     sweep_done;

    modport source (output valid, cell_temp_out, cell_phase_out, sweep_done, input ready);
    modport sink   (input valid, cell_temp_out, cell_phase_out, sweep_done, output ready);
endinterface

interface hpss_cfg_if import hpss_pkg::*; ();
    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] reg_index;
    logic [COEF_W-1:0]    wr_data;

    modport source (output valid, reg_index, wr_data, input ready);
    modport sink   (input valid, reg_index, wr_data, output ready);
endinterface

`default_nettype wire

[design/hpss_front.sv]
// Front end: takes cell beats, keeps the three-cell window and builds one job
// per cell that produces results. Depends on hpss_pkg, hpss_if.
`timescale 1ns / 1ps
`default_nettype none
`include "heat_phase_stencil_step_1d_defines.svh"

module hpss_front import hpss_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    hpss_cell_if.sink i_cell,
    input  logic      i_q_full,
    output logic      o_push,
    output t_job      o_job
);

    localparam logic [1:0] CS_EMPTY = 2'd0;
    localparam logic [1:0] CS_ONE   = 2'd1;
    localparam logic [1:0] CS_MANY  = 2'd2;

    logic signed [DATA_W-1:0] r_left;
    logic signed [DATA_W-1:0] r_mid;
    logic signed [DATA_W-1:0] r_mid_phase;
    logic [1:0]               r_cells_seen;

    logic                  w_accept;
    logic signed [A_W-1:0] w_left_a;
    logic signed [A_W-1:0] w_mid_a;
    logic signed [A_W-1:0] w_temp_a;

    assign i_cell.ready = !i_q_full;
    assign w_accept     = i_cell.valid && i_cell.ready;

    assign w_left_a = {{(A_W-DATA_W){r_left[DATA_W-1]}}, r_left};
    assign w_mid_a  = {{(A_W-DATA_W){r_mid[DATA_W-1]}}, r_mid};
    assign w_temp_a = {{(A_W-DATA_W){i_cell.cell_temp_in[DATA_W-1]}}, i_cell.cell_temp_in};

    // the first cell of a sweep only fills the window, unless it is also the last
    assign o_push = w_accept && ((r_cells_seen != CS_EMPTY) || i_cell.last_in_sweep);

    always_comb begin
        o_job.has_mid   = (r_cells_seen != CS_EMPTY);
        o_job.interior  = (r_cells_seen == CS_MANY);
        o_job.last      = i_cell.last_in_sweep;
        o_job.mid_temp  = r_mid;
        o_job.mid_phase = r_mid_phase;
        o_job.lap       = w_left_a + w_temp_a - (w_mid_a <<< 1);
        o_job.temp      = i_cell.cell_temp_in;
        o_job.phase     = i_cell.cell_phase_in;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_left       <= '0;
            r_mid        <= '0;
            r_mid_phase  <= '0;
            r_cells_seen <= CS_EMPTY;
        end else if (w_accept) begin
            if (i_cell.last_in_sweep) begin
                r_left       <= '0;
                r_mid        <= '0;
                r_mid_phase  <= '0;
                r_cells_seen <= CS_EMPTY;
            end else begin
                r_left      <= r_mid;
                r_mid       <= i_cell.cell_temp_in;
                r_mid_phase <= i_cell.cell_phase_in;
                case (r_cells_seen)
                    CS_EMPTY: r_cells_seen <= CS_ONE;
                    CS_ONE:   r_cells_seen <= CS_MANY;
                    default:  r_cells_seen <= CS_MANY;
                endcase
            end
        end
    end

    `HPSS_ASSERT_NEXT(a_sweep_restart, w_accept && i_cell.last_in_sweep, r_cells_seen == CS_EMPTY, "window not cleared after last cell")

endmodule

`default_nettype wire

[design/hpss_queue.sv]
// Short job queue between front and back end, flops only.
// Depends on hpss_pkg.
`timescale 1ns / 1ps
`default_nettype none
`include "heat_phase_stencil_step_1d_defines.svh"

module hpss_queue import hpss_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_job i_job,
    output logic o_full,
    input  logic i_pop,
    output t_job o_job,
    output logic o_empty
);

    t_job              r_mem [QDEPTH];
    logic [QPTR_W-1:0] r_wr_ptr;
    logic [QPTR_W-1:0] r_rd_ptr;
    logic [QCNT_W-1:0] r_count;

    function automatic logic [QPTR_W-1:0] ptr_inc(input logic [QPTR_W-1:0] p);
        if (p == QPTR_W'(QDEPTH - 1)) begin
            ptr_inc = '0;
        end else begin
            ptr_inc = QPTR_W'(p + 1'b1);
        end
    endfunction

    assign o_full  = (r_count == QCNT_W'(QDEPTH));
    assign o_empty = (r_count == '0);
    assign o_job   = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= ptr_inc(r_wr_ptr);
            end
            if (i_pop) begin
                r_rd_ptr <= ptr_inc(r_rd_ptr);
            end
            case ({i_push, i_pop})
                2'b10:   r_count <= QCNT_W'(r_count + 1'b1);
                2'b01:   r_count <= QCNT_W'(r_count - 1'b1);
                default: r_count <= r_count;
            endcase
        end
    end

    `HPSS_ASSERT_NOW(a_no_overflow, i_push, r_count != QCNT_W'(QDEPTH), "job pushed into full queue")
    `HPSS_ASSERT_NOW(a_no_underflow, i_pop, r_count != '0, "job popped from empty queue")

endmodule

`default_nettype wire

[design/hpss_mulq.sv]
// Shared fixed-point multiplier: exact |a|*|b| on one 17x32 array in two halves,
// scaled by 2^-FRAC_BITS toward zero, sign restored. Depends on hpss_pkg.
`timescale 1ns / 1ps
`default_nettype none

module hpss_mulq import hpss_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_mul_req i_req,
    output t_mul_rsp o_rsp
);

    localparam logic [2:0] M_IDLE = 3'd0;
    localparam logic [2:0] M_LO   = 3'd1;
    localparam logic [2:0] M_HI   = 3'd2;
    localparam logic [2:0] M_SUM  = 3'd3;
    localparam logic [2:0] M_SIGN = 3'd4;

    logic [2:0]              r_state;
    logic [A_W-1:0]          r_mag_a;
    logic [B_W-1:0]          r_mag_b;
    logic                    r_neg;
    logic [LO_W-1:0]         r_lo;
    logic [HI_W-1:0]         r_hi;
    logic [PROD_W-1:0]       r_sum;
    logic signed [RES_W-1:0] r_res;
    logic                    r_done;

    logic [A_W-1:0]   w_mag_a;
    logic [B_W-1:0]   w_mag_b;
    logic [RES_W-1:0] w_mag_q;

    assign w_mag_a = i_req.a[A_W-1] ? A_W'(-i_req.a) : A_W'(i_req.a);
    assign w_mag_b = i_req.b[B_W-1] ? B_W'(-i_req.b) : B_W'(i_req.b);
    assign w_mag_q = {1'b0, r_sum[PROD_W-1:FRAC_BITS]};

    assign o_rsp.done = r_done;
    assign o_rsp.res  = r_res;

    always_ff @(posedge i_clk) begin
        case (r_state)
            M_IDLE: begin
                r_mag_a <= w_mag_a;
                r_mag_b <= w_mag_b;
                r_neg   <= i_req.a[A_W-1] ^ i_req.b[B_W-1];
            end
            M_LO:    r_lo  <= LO_W'(r_mag_a[HALF_W-1:0]) * LO_W'(r_mag_b);
            M_HI:    r_hi  <= HI_W'(r_mag_a[A_W-1:HALF_W]) * HI_W'(r_mag_b);
            M_SUM:   r_sum <= PROD_W'(r_lo) + (PROD_W'(r_hi) << HALF_W);
            M_SIGN:  r_res <= r_neg ? RES_W'(-w_mag_q) : RES_W'(w_mag_q);
            default: r_res <= r_res;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= M_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_done <= (r_state == M_SIGN);
            case (r_state)
                M_IDLE:  r_state <= i_req.start ? M_LO : M_IDLE;
                M_LO:    r_state <= M_HI;
                M_HI:    r_state <= M_SUM;
                M_SUM:   r_state <= M_SIGN;
                default: r_state <= M_IDLE;
            endcase
        end
    end

endmodule

`default_nettype wire

[design/hpss_back.sv]
// Back end: pops jobs, sequences the reaction, phase and temperature updates
// through the shared multiplier and holds the result beat. Depends on hpss_pkg, hpss_if.
`timescale 1ns / 1ps
`default_nettype none
`include "heat_phase_stencil_step_1d_defines.svh"

module hpss_back import hpss_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_q_empty,
    output logic        o_pop,
    input  t_job        i_job,
    input  t_coefs      i_coefs,
    output t_mul_req    o_mul_req,
    input  t_mul_rsp    i_mul_rsp,
    hpss_res_if.source  o_result
);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_R    = 3'd1;  // r = -(1-phi)*T when T<0
    localparam logic [2:0] S_DR   = 3'd2;  // dr = dt*r, new phase
    localparam logic [2:0] S_DIFF = 3'd3;  // diff*laplacian
    localparam logic [2:0] S_LAT  = 3'd4;  // gain*dr, new temperature
    localparam logic [2:0] S_EMIT = 3'd5;

    logic [2:0]               r_state;
    logic                     r_wait;
    logic                     r_sel;      // 0: middle cell, 1: incoming (last) cell
    t_job                     r_job;
    logic signed [DATA_W-1:0] r_r;
    logic signed [DATA_W-1:0] r_dr;
    logic signed [RES_W-1:0]  r_diff;
    logic signed [DATA_W-1:0] r_new_t;
    logic signed [DATA_W-1:0] r_new_p;
    logic                     r_out_valid;
    logic signed [DATA_W-1:0] r_out_temp;
    logic signed [DATA_W-1:0] r_out_phase;
    logic                     r_out_done;

    logic                     w_mul_state;
    logic signed [DATA_W-1:0] w_cur_t;
    logic signed [DATA_W-1:0] w_cur_phi;
    logic signed [A_W-1:0]    w_omp;
    logic signed [WIDE_W-1:0] w_res;
    logic signed [DATA_W-1:0] w_r;
    logic signed [DATA_W-1:0] w_dr;
    logic signed [DATA_W-1:0] w_new_p;
    logic signed [DATA_W-1:0] w_lat;
    logic signed [DATA_W-1:0] w_new_t;
    logic                     w_out_free;

    assign w_cur_t    = r_sel ? r_job.temp : r_job.mid_temp;
    assign w_cur_phi  = r_sel ? r_job.phase : r_job.mid_phase;
    assign w_omp      = ONE_Q - {{(A_W-DATA_W){w_cur_phi[DATA_W-1]}}, w_cur_phi};
    assign w_res      = {{(WIDE_W-RES_W){i_mul_rsp.res[RES_W-1]}}, i_mul_rsp.res};
    assign w_r        = w_cur_t[DATA_W-1] ? sat32(-w_res) : '0;
    assign w_dr       = sat32(w_res);
    assign w_new_p    = sat32(sext_w(w_cur_phi) + sext_w(w_dr));
    assign w_lat      = sat32(w_res);
    assign w_new_t    = sat32(sext_w(r_job.mid_temp)
                        + {{(WIDE_W-RES_W){r_diff[RES_W-1]}}, r_diff}
                        + sext_w(w_lat));
    assign w_out_free = !r_out_valid || o_result.ready;

    assign w_mul_state = r_state inside {S_R, S_DR, S_DIFF, S_LAT};
    assign o_pop       = (r_state == S_IDLE) && !i_q_empty;

    always_comb begin
        o_mul_req.start = w_mul_state && !r_wait;
        o_mul_req.a     = '0;
        o_mul_req.b     = '0;
        case (r_state)
            S_R: begin
                o_mul_req.a = w_omp;
                o_mul_req.b = w_cur_t;
            end
            S_DR: begin
                o_mul_req.a = {{(A_W-COEF_W){1'b0}}, i_coefs.time_step};
                o_mul_req.b = r_r;
            end
            S_DIFF: begin
                o_mul_req.a = r_job.lap;
                o_mul_req.b = {{(B_W-COEF_W){1'b0}}, i_coefs.diffusion_coef};
            end
            S_LAT: begin
                o_mul_req.a = {{(A_W-COEF_W){1'b0}}, i_coefs.latent_gain};
                o_mul_req.b = r_dr;
            end
            default: begin
                o_mul_req.a = '0;
                o_mul_req.b = '0;
            end
        endcase
    end

    assign o_result.valid          = r_out_valid;
    assign o_result.cell_temp_out  = r_out_temp;
    assign o_result.cell_phase_out = r_out_phase;
    assign o_result.sweep_done     = r_out_done;

    // datapath registers
    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                if (!i_q_empty) begin
                    r_job   <= i_job;
                    r_new_t <= i_job.has_mid ? i_job.mid_temp : i_job.temp;
                end
            end
            S_R: begin
                if (i_mul_rsp.done) begin
                    r_r <= w_r;
                end
            end
            S_DR: begin
                if (i_mul_rsp.done) begin
                    r_dr    <= w_dr;
                    r_new_p <= w_new_p;
                end
            end
            S_DIFF: begin
                if (i_mul_rsp.done) begin
                    r_diff <= i_mul_rsp.res;
                end
            end
            S_LAT: begin
                if (i_mul_rsp.done) begin
                    r_new_t <= w_new_t;
                end
            end
            S_EMIT: begin
                if (w_out_free) begin
                    r_out_temp  <= r_new_t;
                    r_out_phase <= r_new_p;
                    r_out_done  <= r_sel;
                end
            end
            default: r_job <= r_job;
        endcase
    end

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_wait      <= 1'b0;
            r_sel       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_mul_req.start) begin
                r_wait <= 1'b1;
            end else if (i_mul_rsp.done) begin
                r_wait <= 1'b0;
            end
            // a new beat may load in the cycle the held one leaves
            if ((r_state == S_EMIT) && w_out_free) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && o_result.ready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (!i_q_empty) begin
                        r_sel   <= !i_job.has_mid;
                        r_state <= S_R;
                    end
                end
                S_R: begin
                    if (i_mul_rsp.done) begin
                        r_state <= S_DR;
                    end
                end
                S_DR: begin
                    if (i_mul_rsp.done) begin
                        r_state <= (!r_sel && r_job.interior) ? S_DIFF : S_EMIT;
                    end
                end
                S_DIFF: begin
                    if (i_mul_rsp.done) begin
                        r_state <= S_LAT;
                    end
                end
                S_LAT: begin
                    if (i_mul_rsp.done) begin
                        r_state <= S_EMIT;
                    end
                end
                S_EMIT: begin
                    if (w_out_free) begin
                        if (!r_sel && r_job.last) begin
                            r_sel   <= 1'b1;
                            r_state <= S_R;
                        end else begin
                            r_state <= S_IDLE;
                        end
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    `HPSS_ASSERT_NOW(a_rsp_expected, i_mul_rsp.done, r_wait && w_mul_state, "multiplier result without a pending request")

endmodule

`default_nettype wire

[design/heat_phase_stencil_step_1d.sv]
// One explicit time step of a 1-D heat equation with phase change, streamed one
// cell per input beat (Q8.24 temperature and phase, last_in_sweep on the final
// cell). A three-cell window updates each cell; results trail the input by one
// cell, the last cell of a sweep produces two result beats (its neighbour, then
// itself with sweep_done), and a first cell that is not last produces none.
// Reaction r = -(1-phi)*T for T<0, phase += dt*r, interior temperature gets
// diff*laplacian + gain*(dt*r); cell 0 keeps T, the last cell copies the new T
// of its neighbour; all results saturate. The front end takes a beat whenever
// its two-entry job queue has room, so bursts are absorbed; sustained rate is
// set by the back end, which runs every product through one shared 17x32
// multiplier, one job at a time. A result beat takes two products for cell 0
// or a one-cell sweep and four for an interior cell; a last cell adds two for
// its own beat. Output is registered, so a stalled sink holds one beat while
// the back end keeps working. Configuration (index 0 diffusion_coef, 1
// time_step, 2 latent_gain; other indexes ignored) is always ready and must
// only be written while idle.
`timescale 1ns / 1ps
`default_nettype none

module heat_phase_stencil_step_1d import hpss_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    hpss_cell_if.sink   i_cell,
    hpss_res_if.source  o_result,
    hpss_cfg_if.sink    i_cfg
);

    t_coefs   r_coefs;
    logic     w_push;
    t_job     w_push_job;
    logic     w_q_full;
    logic     w_q_empty;
    logic     w_pop;
    t_job     w_pop_job;
    t_mul_req w_mul_req;
    t_mul_rsp w_mul_rsp;

    // config writes go straight into the coefficient registers, so the port never back-pressures
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_coefs.diffusion_coef <= DIFFUSION_RST;
            r_coefs.time_step      <= TIME_STEP_RST;
            r_coefs.latent_gain    <= LATENT_RST;
        end else if (i_cfg.valid && i_cfg.ready) begin
            case (i_cfg.reg_index)
                CFG_DIFFUSION: r_coefs.diffusion_coef <= i_cfg.wr_data;
                CFG_TIME_STEP: r_coefs.time_step      <= i_cfg.wr_data;
                CFG_LATENT:    r_coefs.latent_gain    <= i_cfg.wr_data;
                default:       r_coefs                <= r_coefs;
            endcase
        end
    end

    // front end: window and job build
    hpss_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cell   (i_cell),
        .i_q_full (w_q_full),
        .o_push   (w_push),
        .o_job    (w_push_job)
    );

    // decouples beat acceptance from the multi-cycle back end
    hpss_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_job   (w_push_job),
        .o_full  (w_q_full),
        .i_pop   (w_pop),
        .o_job   (w_pop_job),
        .o_empty (w_q_empty)
    );

    // shared scaled multiplier, one request in flight
    hpss_mulq u_mulq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_mul_req),
        .o_rsp   (w_mul_rsp)
    );

    // back end: per-cell update sequence and result register
    hpss_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_empty (w_q_empty),
        .o_pop     (w_pop),
        .i_job     (w_pop_job),
        .i_coefs   (r_coefs),
        .o_mul_req (w_mul_req),
        .i_mul_rsp (w_mul_rsp),
        .o_result  (o_result)
    );

endmodule

`default_nettype wire
